FILE: rtl/pwm_icm_pkg.sv
// ----------------------------------------------------------------------------
// pwm_icm_pkg: shared types and constants of the PWM input capture meter
// Widths, division step counts and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package pwm_icm_pkg;

  localparam int unsigned DATA_W  = 32;             // timestamps, ticks, rate
  localparam int unsigned CNT_W   = 32;             // free-running counter width
  localparam int unsigned DUTY_W  = 14;             // duty in 1/100 %
  localparam int unsigned PROD_W  = DATA_W + DUTY_W;
  localparam int unsigned PER_W   = DATA_W + 1;     // high + low, no overflow

  localparam logic [DATA_W-1:0] CNT_MASK    = DATA_W'((64'd1 << CNT_W) - 64'd1);
  localparam logic [DATA_W-1:0] TICK_RESET  = DATA_W'(1000000);
  localparam logic [DUTY_W-1:0] DUTY_SCALE  = DUTY_W'(10000);

  // one quotient bit per step
  localparam int unsigned FREQ_STEPS = DATA_W;
  localparam int unsigned DUTY_STEPS = DUTY_W;
  localparam int unsigned STEP_W     = $clog2(FREQ_STEPS);

  typedef struct packed {
    logic cap_load;    // latch the incoming timestamp
    logic prev_load;   // previous capture <= timestamp
    logic high_load;   // high time <= difference
    logic low_load;    // low time <= difference
    logic mul_load;    // product, period, start frequency division
    logic div_step;    // one restoring division step
    logic duty_start;  // save frequency, start duty division
    logic duty_save;   // save duty quotient
    logic out_load;    // load the result register
    logic arm_fall;    // result flags
    logic done;
    logic err;
  } icm_cmd_t;

  typedef struct packed {
    logic diff_zero;
  } icm_stat_t;

  typedef struct packed {
    logic              arm_falling_edge;
    logic              measurement_done;
    logic              capture_error;
    logic [DATA_W-1:0] high_ticks;
    logic [DATA_W-1:0] low_ticks;
    logic [DATA_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_hundredths;
  } icm_res_t;

endpackage

FILE: rtl/pwm_icm_if.sv
// ----------------------------------------------------------------------------
// pwm_icm_if: capture and result channels of the PWM input capture meter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface pwm_icm_cap_if
  import pwm_icm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface pwm_icm_res_if
  import pwm_icm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              arm_falling_edge;
  logic              measurement_done;
  logic              capture_error;
  logic [DATA_W-1:0] high_ticks;
  logic [DATA_W-1:0] low_ticks;
  logic [DATA_W-1:0] frequency_hz;
  logic [DUTY_W-1:0] duty_hundredths;

  modport source (output valid, output arm_falling_edge, output measurement_done,
                  output capture_error, output high_ticks, output low_ticks,
                  output frequency_hz, output duty_hundredths, input ready);
  modport sink   (input valid, input arm_falling_edge, input measurement_done,
                  input capture_error, input high_ticks, input low_ticks,
                  input frequency_hz, input duty_hundredths, output ready);
endinterface

FILE: rtl/pwm_icm_dp.sv
// ----------------------------------------------------------------------------
// pwm_icm_dp: datapath of the PWM input capture meter
// Edge differences, measurement registers, duty multiplier, shared divider
// and the result register.
// ----------------------------------------------------------------------------
module pwm_icm_dp
  import pwm_icm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  input  logic [DATA_W-1:0] capture_time_i,
  input  icm_cmd_t          cmd_i,
  output icm_stat_t         stat_o,
  output icm_res_t          res_o
);

  logic [DATA_W-1:0] tick_rate_q;
  logic [DATA_W-1:0] prev_q;
  logic [DATA_W-1:0] high_q;
  logic [DATA_W-1:0] low_q;
  logic [DATA_W-1:0] freq_q;
  logic [DUTY_W-1:0] duty_q;

  logic [DATA_W-1:0] cap_q;
  logic [PROD_W-1:0] prod_q;
  logic [PER_W-1:0]  period_q;
  logic [PER_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] dq_q, dq_d;
  icm_res_t          res_q;

  logic [DATA_W-1:0] diff;
  logic [PER_W:0]    trial_in;
  logic [PER_W:0]    trial;
  logic              fits;

  // difference modulo the counter width
  assign diff             = (cap_q - prev_q) & CNT_MASK;
  assign stat_o.diff_zero = (diff == '0);

  // restoring divider step: shift in next dividend bit, subtract if it fits
  assign trial_in = {rem_q, dq_q[DATA_W-1]};
  assign trial    = trial_in - {1'b0, period_q};
  assign fits     = (trial_in >= {1'b0, period_q});

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    if (cmd_i.mul_load) begin
      rem_d = '0;
      dq_d  = tick_rate_q;
    end else if (cmd_i.duty_start) begin
      // product < period * 2^DUTY_W, so its upper part is already below the divisor
      rem_d = {1'b0, prod_q[PROD_W-1:DUTY_W]};
      dq_d  = {prod_q[DUTY_W-1:0], {(DATA_W-DUTY_W){1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_d = fits ? trial[PER_W-1:0] : trial_in[PER_W-1:0];
      dq_d  = {dq_q[DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RESET;
      prev_q      <= '0;
      high_q      <= '0;
      low_q       <= '0;
      freq_q      <= '0;
      duty_q      <= '0;
    end else begin
      if (cfg_we_i)         tick_rate_q <= cfg_wdata_i;
      if (cmd_i.prev_load)  prev_q      <= cap_q;
      if (cmd_i.high_load)  high_q      <= diff;
      if (cmd_i.low_load)   low_q       <= diff;
      if (cmd_i.duty_start) freq_q      <= dq_q;
      if (cmd_i.duty_save)  duty_q      <= dq_q[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_load) cap_q <= capture_time_i & CNT_MASK;
    if (cmd_i.mul_load) begin
      prod_q   <= {{DUTY_W{1'b0}}, high_q} * {{DATA_W{1'b0}}, DUTY_SCALE};
      period_q <= {1'b0, high_q} + {1'b0, low_q};
    end
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (cmd_i.out_load) begin
      res_q.arm_falling_edge <= cmd_i.arm_fall;
      res_q.measurement_done <= cmd_i.done;
      res_q.capture_error    <= cmd_i.err;
      res_q.high_ticks       <= high_q;
      res_q.low_ticks        <= low_q;
      res_q.frequency_hz     <= freq_q;
      res_q.duty_hundredths  <= duty_q;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/pwm_icm_ctrl.sv
// ----------------------------------------------------------------------------
// pwm_icm_ctrl: controller of the PWM input capture meter
// Edge phase tracking and sequencing of the two divisions and the result.
// ----------------------------------------------------------------------------
module pwm_icm_ctrl
  import pwm_icm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  icm_stat_t stat_i,
  output icm_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_MUL, ST_DIVF, ST_DLOAD, ST_DIVD, ST_DSAVE, ST_WRITE
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_e;

  state_e            state_q;
  phase_e            phase_q;
  logic [STEP_W-1:0] cnt_q;
  logic              arm_q, done_q, err_q, out_valid_q;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.arm_fall = arm_q;
    cmd_o.done     = done_q;
    cmd_o.err      = err_q;
    case (state_q)
      ST_IDLE:  cmd_o.cap_load = in_valid_i;
      ST_EVAL: begin
        case (phase_q)
          PH_HIGH: begin
            cmd_o.high_load = !stat_i.diff_zero;
            cmd_o.prev_load = !stat_i.diff_zero;
          end
          PH_LOW:  cmd_o.low_load  = !stat_i.diff_zero;
          default: cmd_o.prev_load = 1'b1;
        endcase
      end
      ST_MUL:   cmd_o.mul_load   = 1'b1;
      ST_DIVF:  cmd_o.div_step   = 1'b1;
      ST_DLOAD: cmd_o.duty_start = 1'b1;
      ST_DIVD:  cmd_o.div_step   = 1'b1;
      ST_DSAVE: cmd_o.duty_save  = 1'b1;
      ST_WRITE: cmd_o.out_load   = out_free;
      default:  cmd_o.cap_load   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      cnt_q       <= '0;
      arm_q       <= 1'b0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          arm_q  <= 1'b0;
          done_q <= 1'b0;
          err_q  <= 1'b0;
          state_q <= ST_WRITE;
          case (phase_q)
            PH_HIGH: begin
              if (stat_i.diff_zero) begin
                err_q   <= 1'b1;
                phase_q <= PH_FIRST;
              end else begin
                phase_q <= PH_LOW;
              end
            end
            PH_LOW: begin
              phase_q <= PH_FIRST;
              if (stat_i.diff_zero) begin
                err_q <= 1'b1;
              end else begin
                done_q  <= 1'b1;
                state_q <= ST_MUL;
              end
            end
            default: begin
              // first rising edge, also taken for the unused phase code
              arm_q   <= 1'b1;
              phase_q <= PH_HIGH;
            end
          endcase
        end
        ST_MUL: begin
          cnt_q   <= STEP_W'(FREQ_STEPS - 1);
          state_q <= ST_DIVF;
        end
        ST_DIVF: begin
          if (cnt_q == '0) state_q <= ST_DLOAD;
          else             cnt_q   <= cnt_q - 1'b1;
        end
        ST_DLOAD: begin
          cnt_q   <= STEP_W'(DUTY_STEPS - 1);
          state_q <= ST_DIVD;
        end
        ST_DIVD: begin
          if (cnt_q == '0) state_q <= ST_DSAVE;
          else             cnt_q   <= cnt_q - 1'b1;
        end
        ST_DSAVE: state_q <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pwm_input_capture_meter.sv
// ----------------------------------------------------------------------------
// pwm_input_capture_meter: PWM frequency and duty meter from capture stamps
// A period spans a rising, a falling and a rising edge; frequency and duty by a shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  capture_if  in   valid/ready    capture_time
//  result_if   out  valid/ready    flags, high/low ticks, frequency, duty
//  cfg         in   cfg_we_i       tick_rate_hz (reset 1000000)
//
//  An edge that does not complete a period passes through evaluation and the
//  result write; a completing edge also passes through the multiply, the
//  frequency division, the duty load, the duty division and the save, the
//  divider retiring one quotient bit per cycle (32 for frequency, 14 for duty).
//  One item at a time; a new capture is taken while the last result still
//  waits in the output register, a held result stalls the next one. No
//  clearing pass after reset.
// ----------------------------------------------------------------------------
module pwm_input_capture_meter
  import pwm_icm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  pwm_icm_cap_if.sink       capture_if,
  pwm_icm_res_if.source     result_if
);

  icm_cmd_t  cmd;
  icm_stat_t stat;
  icm_res_t  res;

  pwm_icm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (capture_if.valid),
    .in_ready_o  (capture_if.ready),
    .out_valid_o (result_if.valid),
    .out_ready_i (result_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pwm_icm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .capture_time_i (capture_if.capture_time),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .res_o          (res)
  );

  assign result_if.arm_falling_edge = res.arm_falling_edge;
  assign result_if.measurement_done = res.measurement_done;
  assign result_if.capture_error    = res.capture_error;
  assign result_if.high_ticks       = res.high_ticks;
  assign result_if.low_ticks        = res.low_ticks;
  assign result_if.frequency_hz     = res.frequency_hz;
  assign result_if.duty_hundredths  = res.duty_hundredths;

  // at most one of the three flags on any result
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_if.valid |-> $onehot0({result_if.arm_falling_edge,
                                  result_if.measurement_done,
                                  result_if.capture_error}))
    else $error("result flags not exclusive");

  // duty never exceeds one hundred percent
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_if.valid |-> (result_if.duty_hundredths <= DUTY_SCALE))
    else $error("duty out of range");

  // one capture in flight: ready drops after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (capture_if.valid && capture_if.ready) |=> !capture_if.ready)
    else $error("capture accepted while busy");

  // result register only reloads once the old result is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_if.valid && !result_if.ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

FILE: tb/tb_pwm_input_capture_meter.sv
// ----------------------------------------------------------------------------
// tb_pwm_input_capture_meter: self-checking bench for the PWM capture meter
// Feeds capture stamps as rising/falling/rising triples with random spans,
// stray edges and equal stamps. Every result is checked field by field
// against an in-bench model of the phase sequence and the two divisions.
// The tick rate is changed between phases, 0, 1 and full scale among them.
// ----------------------------------------------------------------------------
module tb_pwm_input_capture_meter;
  import pwm_icm_pkg::*;

  localparam int DUTY_FULL    = 10000;
  localparam int LONG_STALL   = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_TICKS = 60;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic [1:0] {
    AWAIT_RISE      = 2'd0,
    AWAIT_FALL      = 2'd1,
    AWAIT_NEXT_RISE = 2'd2
  } edge_phase_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [DATA_W-1:0] cfg_wdata_i = '0;

  pwm_icm_cap_if capture_bus ();
  pwm_icm_res_if result_bus ();

  pwm_input_capture_meter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .capture_if  (capture_bus),
    .result_if   (result_bus)
  );

  always #10 clk_i = ~clk_i;

  // meter model state
  edge_phase_e       meter_phase;
  logic [DATA_W-1:0] model_tick_rate;
  logic [DATA_W-1:0] last_stamp;
  logic [DATA_W-1:0] held_high;
  logic [DATA_W-1:0] held_low;
  logic [DATA_W-1:0] held_freq;
  logic [DUTY_W-1:0] held_duty;

  logic [DATA_W-1:0] pending_stamps[$];
  icm_res_t          expected_readings[$];
  icm_res_t          want;

  bit cap_fire;
  bit res_fire;
  bit idling_on       = 1'b1;
  bit long_stall_req  = 1'b0;
  int cap_gap         = 0;
  int res_gap         = 0;
  int long_stall_left = 0;
  int idle_cycles     = 0;

  int stamps_queued   = 0;
  int results_checked = 0;
  int periods_seen    = 0;
  int restarts_seen   = 0;
  int rate_writes     = 0;
  int mismatch_count  = 0;

  function automatic icm_res_t meter_next_reading(input logic [DATA_W-1:0] raw_stamp);
    icm_res_t          r;
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] span;
    logic [PER_W-1:0]  period;
    r     = '0;
    stamp = raw_stamp & CNT_MASK;
    span  = (stamp - last_stamp) & CNT_MASK;
    case (meter_phase)
      AWAIT_FALL: begin
        if (span == '0) begin
          r.capture_error = 1'b1;
          meter_phase     = AWAIT_RISE;
        end else begin
          held_high   = span;
          last_stamp  = stamp;
          meter_phase = AWAIT_NEXT_RISE;
        end
      end
      AWAIT_NEXT_RISE: begin
        if (span == '0) begin
          r.capture_error = 1'b1;
        end else begin
          held_low  = span;
          // 33-bit sum, cannot wrap
          period    = {1'b0, held_high} + {1'b0, held_low};
          held_freq = DATA_W'(64'(model_tick_rate) / 64'(period));
          held_duty = DUTY_W'((64'(held_high) * 64'(DUTY_FULL)) / 64'(period));
          r.measurement_done = 1'b1;
        end
        meter_phase = AWAIT_RISE;
      end
      default: begin
        last_stamp         = stamp;
        r.arm_falling_edge = 1'b1;
        meter_phase        = AWAIT_FALL;
      end
    endcase
    r.high_ticks      = held_high;
    r.low_ticks       = held_low;
    r.frequency_hz    = held_freq;
    r.duty_hundredths = held_duty;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH %s: got %h exp %h at result %0d", what, got, exp_val,
               results_checked);
  endtask

  // monitor: model update on each capture transfer, check on each result
  always @(posedge clk_i) begin
    cap_fire = rst_ni && capture_bus.valid && capture_bus.ready;
    res_fire = rst_ni && result_bus.valid && result_bus.ready;
    if (rst_ni && cfg_we_i) model_tick_rate = cfg_wdata_i;
    if (cap_fire) expected_readings.push_back(meter_next_reading(capture_bus.capture_time));
    if (res_fire) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = expected_readings.pop_front();
        if (result_bus.arm_falling_edge !== want.arm_falling_edge)
          report_mismatch("arm_falling_edge", result_bus.arm_falling_edge,
                          want.arm_falling_edge);
        if (result_bus.measurement_done !== want.measurement_done)
          report_mismatch("measurement_done", result_bus.measurement_done,
                          want.measurement_done);
        if (result_bus.capture_error !== want.capture_error)
          report_mismatch("capture_error", result_bus.capture_error, want.capture_error);
        if (result_bus.high_ticks !== want.high_ticks)
          report_mismatch("high_ticks", result_bus.high_ticks, want.high_ticks);
        if (result_bus.low_ticks !== want.low_ticks)
          report_mismatch("low_ticks", result_bus.low_ticks, want.low_ticks);
        if (result_bus.frequency_hz !== want.frequency_hz)
          report_mismatch("frequency_hz", result_bus.frequency_hz, want.frequency_hz);
        if (result_bus.duty_hundredths !== want.duty_hundredths)
          report_mismatch("duty_hundredths", result_bus.duty_hundredths,
                          want.duty_hundredths);
        if (want.measurement_done) periods_seen++;
        if (want.capture_error) restarts_seen++;
      end
      results_checked++;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || cap_fire || res_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // capture driver
  always @(negedge clk_i) begin
    if (rst_ni && !(capture_bus.valid && !cap_fire)) begin
      if (cap_gap > 0) begin
        cap_gap--;
        capture_bus.valid <= 1'b0;
      end else if (pending_stamps.size() > 0) begin
        capture_bus.valid        <= 1'b1;
        capture_bus.capture_time <= pending_stamps.pop_front();
        if (idling_on && $urandom_range(0, 5) == 0) cap_gap = $urandom_range(1, 6);
      end else begin
        capture_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (long_stall_req) begin
      long_stall_left = LONG_STALL;
      long_stall_req  = 1'b0;
    end
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else if (long_stall_left > 0) begin
      long_stall_left--;
      result_bus.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) res_gap = $urandom_range(1, 6);
    end
  end

  task automatic push_stamp(input logic [DATA_W-1:0] stamp);
    pending_stamps.push_back(stamp);
    stamps_queued++;
  endtask

  task automatic push_period(input logic [DATA_W-1:0] rise, input logic [DATA_W-1:0] high_span,
                             input logic [DATA_W-1:0] low_span);
    push_stamp(rise);
    push_stamp(rise + high_span);
    // a zero high span restarts after the second stamp, so keep in step
    if (high_span != '0) push_stamp(rise + high_span + low_span);
  endtask

  function automatic logic [DATA_W-1:0] pick_span();
    case ($urandom_range(0, 19))
      0:             return '0;
      1, 2, 3, 4, 5: return DATA_W'($urandom_range(1, 64));
      6, 7, 8, 9:    return DATA_W'($urandom_range(1, 100000));
      10:            return '1 - DATA_W'($urandom_range(0, 3));
      default:       return DATA_W'($urandom);
    endcase
  endfunction

  task automatic run_random_periods(input int count);
    int target;
    target = stamps_queued + count;
    while (stamps_queued < target) begin
      // stray edge throws the sequence out of step
      if ($urandom_range(0, 24) == 0) push_stamp(DATA_W'($urandom));
      else push_period(DATA_W'($urandom), pick_span(), pick_span());
    end
  endtask

  task automatic wait_all_done();
    while (pending_stamps.size() != 0 || capture_bus.valid || expected_readings.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_tick_rate(input logic [DATA_W-1:0] rate);
    wait_all_done();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    rate_writes++;
  endtask

  initial begin
    meter_phase              = AWAIT_RISE;
    model_tick_rate          = TICK_RESET;
    last_stamp               = '0;
    held_high                = '0;
    held_low                 = '0;
    held_freq                = '0;
    held_duty                = '0;
    capture_bus.valid        = 1'b0;
    capture_bus.capture_time = '0;
    result_bus.ready         = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset tick rate
    push_period('0, 32'd1, 32'd1);
    push_period(32'hFFFF_FFF0, 32'h20, 32'h30);             // counter wrap
    push_period(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // widest period
    push_period(32'd9, 32'd1, 32'hFFFF_FFFF);               // duty rounds to 0
    push_period(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);       // duty just under full
    push_period(32'd7, '0, 32'd1);                          // equal stamp on falling edge
    push_period(32'd100, 32'd100, '0);                      // equal stamp on closing edge
    set_tick_rate('0);
    push_period(32'd1000, 32'd1000, 32'd3000);
    set_tick_rate('1);
    push_period(32'd42, 32'd1, 32'd1);

    // random periods across several tick rates
    run_random_periods(80);
    set_tick_rate(32'd1);
    run_random_periods(80);
    long_stall_req = 1'b1;                                  // sender keeps offering
    set_tick_rate(DATA_W'($urandom));
    run_random_periods(40);
    push_stamp(32'h1234_0000);
    push_stamp(32'h1234_0100);
    wait_all_done();                                        // pause mid-period
    push_stamp(32'h1234_0400);
    run_random_periods(40);
    set_tick_rate(TICK_RESET);
    run_random_periods(80);
    wait_all_done();
    idling_on = 1'b0;
    run_random_periods(80);

    wait_all_done();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    while (expected_readings.size() != 0) begin
      void'(expected_readings.pop_front());
      report_mismatch("result never arrived", '0, '0);
    end

    $display("Checked %0d results from %0d stamps: %0d periods measured, %0d restarts",
             results_checked, stamps_queued, periods_seen, restarts_seen);
    $display("Tick rate written %0d times incl. 0, 1 and full scale; long output stall done",
             rate_writes);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
